/* design/lclr_pkg.sv */
package lclr_pkg;

  // Field and register widths
  localparam int DATA_W       = 32;
  localparam int ACT_W        = 5;
  localparam int CMD_W        = 2;
  localparam int CLIENT_W     = 4;
  localparam int CFG_IDX_W    = 2;
  localparam int QCNT_W       = $clog2(DATA_W);
  localparam int CLIENTS_DEF  = 16;
  localparam int PREFILL_DIV  = 2;

  localparam logic [DATA_W-1:0] LIMIT_RESET  = 32'd10000;
  localparam logic [ACT_W-1:0]  ACTIVE_RESET = 5'd1;

  // Commands
  localparam logic [CMD_W-1:0] CMD_ADD     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SUB     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 2'd1;

  // Datapath operations, one per microcode step
  typedef enum logic [4:0] {
    OP_NOP       = 5'd0,
    OP_ACCEPT    = 5'd1,
    OP_FETCH     = 5'd2,
    OP_LOAD      = 5'd3,
    OP_DIFF      = 5'd4,
    OP_FIT       = 5'd5,
    OP_FOLD_P    = 5'd6,
    OP_FOLD_R    = 5'd7,
    OP_WB        = 5'd8,
    OP_HSUM      = 5'd9,
    OP_HEAD      = 5'd10,
    OP_HTEST     = 5'd11,
    OP_POOL_ADD  = 5'd12,
    OP_PTEST     = 5'd13,
    OP_POOL_SUB  = 5'd14,
    OP_DIV_START = 5'd15,
    OP_SET_RES   = 5'd16,
    OP_FILL      = 5'd17,
    OP_LC_ADD    = 5'd18,
    OP_SUBCHK    = 5'd19,
    OP_LC_SUB    = 5'd20,
    OP_WALK_RD   = 5'd21,
    OP_WALK_ACC  = 5'd22,
    OP_FIN_READ  = 5'd23,
    OP_FIN_OK    = 5'd24,
    OP_FIN_FAIL  = 5'd25
  } op_t;

  // Jump conditions
  typedef enum logic [3:0] {
    C_NEVER      = 4'd0,
    C_ALWAYS     = 4'd1,
    C_ITEM       = 4'd2,
    C_IS_READ    = 4'd3,
    C_BAD_CLIENT = 4'd4,
    C_IS_REL     = 4'd5,
    C_IS_SUB     = 4'd6,
    C_FLAG       = 4'd7,
    C_NOT_FLAG   = 4'd8,
    C_WALK_MORE  = 4'd9,
    C_DIV_DONE   = 4'd10,
    C_OUT_FREE   = 4'd11
  } cond_t;

  typedef logic [5:0] step_t;

  // Program addresses
  localparam step_t ST_IDLE    = 6'd0;
  localparam step_t ST_FETCH   = 6'd1;
  localparam step_t ST_LOAD    = 6'd2;
  localparam step_t ST_ISREL   = 6'd3;
  localparam step_t ST_ISSUB   = 6'd4;
  localparam step_t ST_DIFF    = 6'd5;
  localparam step_t ST_FIT     = 6'd6;
  localparam step_t ST_FASTQ   = 6'd7;
  localparam step_t ST_FOLDP   = 6'd8;
  localparam step_t ST_FOLDR   = 6'd9;
  localparam step_t ST_FOLDWB  = 6'd10;
  localparam step_t ST_AFTFOLD = 6'd11;
  localparam step_t ST_AHSUM   = 6'd12;
  localparam step_t ST_AHEAD   = 6'd13;
  localparam step_t ST_HTEST   = 6'd14;
  localparam step_t ST_HCHK    = 6'd15;
  localparam step_t ST_PADD    = 6'd16;
  localparam step_t ST_PTEST   = 6'd17;
  localparam step_t ST_PCHK    = 6'd18;
  localparam step_t ST_PSUB    = 6'd19;
  localparam step_t ST_RHSUM   = 6'd20;
  localparam step_t ST_RHEAD   = 6'd21;
  localparam step_t ST_DIVGO   = 6'd22;
  localparam step_t ST_DIVWT   = 6'd23;
  localparam step_t ST_SETRES  = 6'd24;
  localparam step_t ST_FILL    = 6'd25;
  localparam step_t ST_WB      = 6'd26;
  localparam step_t ST_AFAST   = 6'd27;
  localparam step_t ST_SCHK    = 6'd28;
  localparam step_t ST_SCHKJ   = 6'd29;
  localparam step_t ST_SFAST   = 6'd30;
  localparam step_t ST_WALK0   = 6'd31;
  localparam step_t ST_WALK    = 6'd32;
  localparam step_t ST_RDONE   = 6'd33;
  localparam step_t ST_OK      = 6'd34;
  localparam step_t ST_FAIL    = 6'd35;

  // One control word: operation, jump condition, hold-on-false, jump target
  typedef struct packed {
    op_t   op;
    cond_t cond;
    logic  hold;
    step_t target;
  } uword_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic item;
    logic is_read;
    logic bad_client;
    logic is_rel;
    logic is_sub;
    logic flag;
    logic walk_more;
    logic div_done;
    logic out_free;
  } status_t;

  // Saturating 32-bit add
  function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b);
    logic [DATA_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DATA_W] ? {DATA_W{1'b1}} : s[DATA_W-1:0];
  endfunction

  // Microcode ROM
  function automatic uword_t ucode(input step_t pc);
    uword_t w;
    unique case (pc)
      ST_IDLE:    w = '{OP_ACCEPT,    C_ITEM,       1'b1, ST_FETCH};
      ST_FETCH:   w = '{OP_FETCH,     C_IS_READ,    1'b0, ST_WALK0};
      ST_LOAD:    w = '{OP_LOAD,      C_BAD_CLIENT, 1'b0, ST_FAIL};
      ST_ISREL:   w = '{OP_NOP,       C_IS_REL,     1'b0, ST_FOLDP};
      ST_ISSUB:   w = '{OP_NOP,       C_IS_SUB,     1'b0, ST_SCHK};
      ST_DIFF:    w = '{OP_DIFF,      C_NEVER,      1'b0, ST_IDLE};
      ST_FIT:     w = '{OP_FIT,       C_NEVER,      1'b0, ST_IDLE};
      ST_FASTQ:   w = '{OP_NOP,       C_FLAG,       1'b0, ST_AFAST};
      ST_FOLDP:   w = '{OP_FOLD_P,    C_NEVER,      1'b0, ST_IDLE};
      ST_FOLDR:   w = '{OP_FOLD_R,    C_NEVER,      1'b0, ST_IDLE};
      ST_FOLDWB:  w = '{OP_WB,        C_IS_REL,     1'b0, ST_OK};
      ST_AFTFOLD: w = '{OP_NOP,       C_IS_SUB,     1'b0, ST_PTEST};
      ST_AHSUM:   w = '{OP_HSUM,      C_NEVER,      1'b0, ST_IDLE};
      ST_AHEAD:   w = '{OP_HEAD,      C_NEVER,      1'b0, ST_IDLE};
      ST_HTEST:   w = '{OP_HTEST,     C_NEVER,      1'b0, ST_IDLE};
      ST_HCHK:    w = '{OP_NOP,       C_NOT_FLAG,   1'b0, ST_FAIL};
      ST_PADD:    w = '{OP_POOL_ADD,  C_ALWAYS,     1'b0, ST_RHSUM};
      ST_PTEST:   w = '{OP_PTEST,     C_NEVER,      1'b0, ST_IDLE};
      ST_PCHK:    w = '{OP_NOP,       C_NOT_FLAG,   1'b0, ST_FAIL};
      ST_PSUB:    w = '{OP_POOL_SUB,  C_NEVER,      1'b0, ST_IDLE};
      ST_RHSUM:   w = '{OP_HSUM,      C_NEVER,      1'b0, ST_IDLE};
      ST_RHEAD:   w = '{OP_HEAD,      C_NEVER,      1'b0, ST_IDLE};
      ST_DIVGO:   w = '{OP_DIV_START, C_NEVER,      1'b0, ST_IDLE};
      ST_DIVWT:   w = '{OP_NOP,       C_DIV_DONE,   1'b1, ST_SETRES};
      ST_SETRES:  w = '{OP_SET_RES,   C_NEVER,      1'b0, ST_IDLE};
      ST_FILL:    w = '{OP_FILL,      C_NEVER,      1'b0, ST_IDLE};
      ST_WB:      w = '{OP_WB,        C_ALWAYS,     1'b0, ST_OK};
      ST_AFAST:   w = '{OP_LC_ADD,    C_ALWAYS,     1'b0, ST_WB};
      ST_SCHK:    w = '{OP_SUBCHK,    C_NEVER,      1'b0, ST_IDLE};
      ST_SCHKJ:   w = '{OP_NOP,       C_NOT_FLAG,   1'b0, ST_FOLDP};
      ST_SFAST:   w = '{OP_LC_SUB,    C_ALWAYS,     1'b0, ST_WB};
      ST_WALK0:   w = '{OP_WALK_RD,   C_NEVER,      1'b0, ST_IDLE};
      ST_WALK:    w = '{OP_WALK_ACC,  C_WALK_MORE,  1'b0, ST_WALK};
      ST_RDONE:   w = '{OP_FIN_READ,  C_OUT_FREE,   1'b1, ST_IDLE};
      ST_OK:      w = '{OP_FIN_OK,    C_OUT_FREE,   1'b1, ST_IDLE};
      ST_FAIL:    w = '{OP_FIN_FAIL,  C_OUT_FREE,   1'b1, ST_IDLE};
      default:    w = '{OP_NOP,       C_ALWAYS,     1'b0, ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

/* design/lclr_seq.sv */
// Microcode sequencer: step counter, control ROM and jump logic
module lclr_seq (
  input  logic              clk,
  input  logic              rst,
  input  lclr_pkg::status_t st,
  output lclr_pkg::op_t     op
);

  lclr_pkg::step_t  pc;
  lclr_pkg::step_t  pc_next;
  lclr_pkg::uword_t uw;
  logic             take;

  assign uw = lclr_pkg::ucode(pc);
  assign op = uw.op;

  // Condition select
  always_comb begin
    unique case (uw.cond)
      lclr_pkg::C_NEVER:      take = 1'b0;
      lclr_pkg::C_ALWAYS:     take = 1'b1;
      lclr_pkg::C_ITEM:       take = st.item;
      lclr_pkg::C_IS_READ:    take = st.is_read;
      lclr_pkg::C_BAD_CLIENT: take = st.bad_client;
      lclr_pkg::C_IS_REL:     take = st.is_rel;
      lclr_pkg::C_IS_SUB:     take = st.is_sub;
      lclr_pkg::C_FLAG:       take = st.flag;
      lclr_pkg::C_NOT_FLAG:   take = !st.flag;
      lclr_pkg::C_WALK_MORE:  take = st.walk_more;
      lclr_pkg::C_DIV_DONE:   take = st.div_done;
      lclr_pkg::C_OUT_FREE:   take = st.out_free;
      default:                take = 1'b0;
    endcase
  end

  // Jump, hold or step on
  always_comb begin
    if (take) begin
      pc_next = uw.target;
    end else if (uw.hold) begin
      pc_next = pc;
    end else begin
      pc_next = pc + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= lclr_pkg::ST_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

/* design/lclr_div.sv */
// Restoring divider, one quotient bit per cycle
module lclr_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [lclr_pkg::DATA_W-1:0]   dividend,
  input  logic [lclr_pkg::ACT_W-1:0]    divisor,
  output logic                          busy,
  output logic [lclr_pkg::DATA_W-1:0]   quot
);

  logic [lclr_pkg::QCNT_W-1:0] cnt;
  logic [lclr_pkg::ACT_W-1:0]  rem;
  logic [lclr_pkg::ACT_W-1:0]  dvs;
  logic [lclr_pkg::ACT_W:0]    trial;
  logic [lclr_pkg::ACT_W:0]    diff;
  logic                        ge;

  assign trial = {rem, quot[lclr_pkg::DATA_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == '0) begin
      busy <= 1'b0;
    end
  end

  // Shift dividend out, quotient bits in
  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dvs  <= divisor;
      cnt  <= {lclr_pkg::QCNT_W{1'b1}};
    end else if (busy) begin
      quot <= {quot[lclr_pkg::DATA_W-2:0], ge};
      rem  <= ge ? diff[lclr_pkg::ACT_W-1:0] : trial[lclr_pkg::ACT_W-1:0];
      cnt  <= cnt - 1'b1;
    end
  end

endmodule

/* design/lclr_dp.sv */
// Datapath: pooled values, local store, working registers, result register
module lclr_dp #(
  parameter int CLIENTS = lclr_pkg::CLIENTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  lclr_pkg::op_t                   op,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [lclr_pkg::CMD_W-1:0]      command,
  input  logic [lclr_pkg::CLIENT_W-1:0]   client,
  input  logic [lclr_pkg::DATA_W-1:0]     delta,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            ok,
  output logic [lclr_pkg::DATA_W-1:0]     total,
  input  logic [lclr_pkg::DATA_W-1:0]     count_limit,
  input  logic [lclr_pkg::ACT_W-1:0]      active_clients,
  output lclr_pkg::status_t               st
);

  localparam int IW = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
  localparam int WW = $clog2(CLIENTS + 1);
  localparam int DW = lclr_pkg::DATA_W;

  // Latched item
  logic [lclr_pkg::CMD_W-1:0]    cmd_r;
  logic [lclr_pkg::CLIENT_W-1:0] client_r;
  logic [DW-1:0]                 delta_r;

  // State and working registers
  logic [DW-1:0] pooled;
  logic [DW-1:0] reserved;
  logic [DW-1:0] lc;
  logic [DW-1:0] lr;
  logic [DW:0]   tmp;
  logic [DW-1:0] head;
  logic [DW-1:0] acc;
  logic          flag;
  logic [WW-1:0] wcnt;

  // Local store
  logic [DW-1:0] cnt_mem [CLIENTS];
  logic [DW-1:0] res_mem [CLIENTS];
  logic          vld     [CLIENTS];
  logic [DW-1:0] rd_cnt;
  logic [DW-1:0] rd_res;
  logic          rd_vld;
  logic [DW-1:0] rd_cnt_e;
  logic [DW-1:0] rd_res_e;
  logic [IW-1:0] cidx;
  logic [IW-1:0] raddr;

  // Divider hookup
  logic              div_busy;
  logic [DW-1:0]     quot;
  logic [lclr_pkg::ACT_W-1:0] dvs_in;

  // Misc combinational
  logic          out_free;
  logic          fin;
  logic [DW:0]   limit_x;
  logic [DW:0]   head_diff;
  logic [DW-1:0] half_q;
  logic [DW-1:0] fill;

  assign cidx     = IW'(client_r);
  assign raddr    = (op == lclr_pkg::OP_FETCH) ? cidx : wcnt[IW-1:0];
  assign rd_cnt_e = rd_vld ? rd_cnt : '0;
  assign rd_res_e = rd_vld ? rd_res : '0;
  assign in_ready = (op == lclr_pkg::OP_ACCEPT);
  assign out_free = !out_valid || out_ready;
  assign fin      = (op == lclr_pkg::OP_FIN_READ) || (op == lclr_pkg::OP_FIN_OK) ||
                    (op == lclr_pkg::OP_FIN_FAIL);
  assign limit_x  = {1'b0, count_limit};
  assign head_diff = limit_x - tmp;
  assign half_q   = quot / lclr_pkg::PREFILL_DIV;
  assign fill     = (half_q > pooled) ? pooled : half_q;
  assign dvs_in   = (active_clients == '0) ? lclr_pkg::ACT_W'(1) : active_clients;

  lclr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (op == lclr_pkg::OP_DIV_START),
    .dividend (head),
    .divisor  (dvs_in),
    .busy     (div_busy),
    .quot     (quot)
  );

  // Status for jump conditions
  always_comb begin
    st.item       = in_valid;
    st.is_read    = (cmd_r == lclr_pkg::CMD_READ);
    st.bad_client = (32'(client_r) >= 32'(CLIENTS));
    st.is_rel     = (cmd_r == lclr_pkg::CMD_RELEASE);
    st.is_sub     = (cmd_r == lclr_pkg::CMD_SUB);
    st.flag       = flag;
    st.walk_more  = (wcnt < WW'(CLIENTS));
    st.div_done   = !div_busy;
    st.out_free   = out_free;
  end

  // Local store: registered read, write-back of one client
  always_ff @(posedge clk) begin
    rd_cnt <= cnt_mem[raddr];
    rd_res <= res_mem[raddr];
    rd_vld <= vld[raddr];
    if (op == lclr_pkg::OP_WB) begin
      cnt_mem[cidx] <= lc;
      res_mem[cidx] <= lr;
    end
  end

  // Entry valid bits; an unwritten entry reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CLIENTS; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (op == lclr_pkg::OP_WB) begin
      vld[cidx] <= 1'b1;
    end
  end

  // Pooled count and reserved total
  always_ff @(posedge clk) begin
    if (rst) begin
      pooled   <= '0;
      reserved <= '0;
    end else begin
      case (op)
        lclr_pkg::OP_FOLD_P:   pooled <= lclr_pkg::sat_add(pooled, lc);
        lclr_pkg::OP_FOLD_R:   reserved <= (reserved >= lr) ? reserved - lr : '0;
        lclr_pkg::OP_POOL_ADD: pooled <= pooled + delta_r;
        lclr_pkg::OP_POOL_SUB: pooled <= pooled - delta_r;
        lclr_pkg::OP_SET_RES:  reserved <= lclr_pkg::sat_add(reserved, quot);
        lclr_pkg::OP_FILL:     pooled <= pooled - fill;
        default: ;
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (op)
      lclr_pkg::OP_ACCEPT: begin
        if (in_valid) begin
          cmd_r    <= command;
          client_r <= client;
          delta_r  <= delta;
        end
      end
      lclr_pkg::OP_FETCH: begin
        acc  <= pooled;
        wcnt <= '0;
      end
      lclr_pkg::OP_LOAD: begin
        lc <= rd_cnt_e;
        lr <= rd_res_e;
      end
      lclr_pkg::OP_DIFF: begin
        tmp  <= {1'b0, lr - lc};
        flag <= (lc <= lr);
      end
      lclr_pkg::OP_FIT:     flag <= flag && (tmp[DW-1:0] >= delta_r);
      lclr_pkg::OP_FOLD_P:  lc <= '0;
      lclr_pkg::OP_FOLD_R:  lr <= '0;
      lclr_pkg::OP_HSUM:    tmp <= {1'b0, pooled} + {1'b0, reserved};
      lclr_pkg::OP_HEAD:    head <= (limit_x > tmp) ? head_diff[DW-1:0] : '0;
      lclr_pkg::OP_HTEST:   flag <= (head >= delta_r);
      lclr_pkg::OP_PTEST:   flag <= (pooled >= delta_r);
      lclr_pkg::OP_SET_RES: lr <= quot;
      lclr_pkg::OP_FILL:    lc <= fill;
      lclr_pkg::OP_LC_ADD:  lc <= lc + delta_r;
      lclr_pkg::OP_SUBCHK:  flag <= (lc >= delta_r);
      lclr_pkg::OP_LC_SUB:  lc <= lc - delta_r;
      lclr_pkg::OP_WALK_RD: wcnt <= WW'(1);
      lclr_pkg::OP_WALK_ACC: begin
        acc <= lclr_pkg::sat_add(acc, rd_cnt_e);
        if (wcnt < WW'(CLIENTS)) begin
          wcnt <= wcnt + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin && out_free) begin
      ok    <= (op != lclr_pkg::OP_FIN_FAIL);
      total <= (op == lclr_pkg::OP_FIN_READ) ? acc : '0;
    end
  end

endmodule

/* design/limit_counter_with_local_reserves.sv */
// Bounded shared counter with per-client local counts and reserves. One item
// is taken at a time and gives exactly one result (ok, total). An add that fits
// the client's local reserve, or a subtract covered by the local count, is done
// locally; one that falls back to the pooled values waits on the bit-serial
// division of the free headroom by active_clients. A read walks the local
// store one client per cycle. A finished result waits in an output register,
// and the next item is accepted while it waits. The user must write
// configuration (index 0 count_limit, index 1 active_clients) only while idle;
// the block itself does not enforce it.
module limit_counter_with_local_reserves #(
  parameter int CLIENTS = lclr_pkg::CLIENTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [lclr_pkg::CMD_W-1:0]         command,
  input  logic [lclr_pkg::CLIENT_W-1:0]      client,
  input  logic [lclr_pkg::DATA_W-1:0]        delta,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               ok,
  output logic [lclr_pkg::DATA_W-1:0]        total,
  input  logic                               cfg_we,
  input  logic [lclr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lclr_pkg::DATA_W-1:0]        cfg_data
);

  logic [lclr_pkg::DATA_W-1:0] count_limit;
  logic [lclr_pkg::ACT_W-1:0]  active_clients;
  lclr_pkg::op_t               op;
  lclr_pkg::status_t           st;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count_limit    <= lclr_pkg::LIMIT_RESET;
      active_clients <= lclr_pkg::ACTIVE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        lclr_pkg::CFG_LIMIT:  count_limit <= cfg_data;
        lclr_pkg::CFG_ACTIVE: active_clients <= cfg_data[lclr_pkg::ACT_W-1:0];
        default: ;
      endcase
    end
  end

  lclr_seq u_seq (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .op  (op)
  );

  lclr_dp #(
    .CLIENTS (CLIENTS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .op             (op),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .client         (client),
    .delta          (delta),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .ok             (ok),
    .total          (total),
    .count_limit    (count_limit),
    .active_clients (active_clients),
    .st             (st)
  );

  // Accepted item moves the program on to the local fetch
  a_accept_fetch: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (op == lclr_pkg::OP_FETCH))
    else $error("accepted item did not advance to fetch");

  // Divider goes busy right after start
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    (op == lclr_pkg::OP_DIV_START) |=> !st.div_done)
    else $error("divider not busy after start");

  // Failed item posts ok low
  a_fail_result: assert property (@(posedge clk) disable iff (rst)
    (op == lclr_pkg::OP_FIN_FAIL && st.out_free) |=> (out_valid && !ok))
    else $error("failed item result not posted");

endmodule

/* bench/limit_counter_with_local_reserves_tb.sv */
module limit_counter_with_local_reserves_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DATA_W       = lclr_pkg::DATA_W;
  localparam int ACT_W        = lclr_pkg::ACT_W;
  localparam int CMD_W        = lclr_pkg::CMD_W;
  localparam int CLIENT_W     = lclr_pkg::CLIENT_W;
  localparam int CFG_IDX_W    = lclr_pkg::CFG_IDX_W;

  localparam int NCLI         = lclr_pkg::CLIENTS_DEF;
  localparam int LIMIT_CYCLES = 1_500_000;
  localparam int HOLD_CYCLES  = 700;
  localparam int NPHASE       = 7;

  // Unused register slots, written to show they are ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef struct packed {
    logic              ok;
    logic [DATA_W-1:0] total;
  } reply_t;

  // Directed row: item plus an optional hand-written reply
  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [CLIENT_W-1:0] cl;
    logic [DATA_W-1:0]   d;
    logic                fixed;
    logic                ok;
    logic [DATA_W-1:0]   tot;
  } dir_row_t;

  localparam int DIR_N = 20;
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    '{lclr_pkg::CMD_READ,    4'd0,  32'd0,          1'b1, 1'b1, 32'd0},
    '{lclr_pkg::CMD_ADD,     4'd0,  32'd0,          1'b1, 1'b1, 32'd0},
    '{lclr_pkg::CMD_ADD,     4'd1,  32'd10001,      1'b1, 1'b0, 32'd0},
    '{lclr_pkg::CMD_SUB,     4'd2,  32'd1,          1'b1, 1'b0, 32'd0},
    '{lclr_pkg::CMD_ADD,     4'd3,  32'hFFFF_FFFF,  1'b1, 1'b0, 32'd0},
    '{lclr_pkg::CMD_SUB,     4'd15, 32'd0,          1'b1, 1'b1, 32'd0},
    '{lclr_pkg::CMD_RELEASE, 4'd5,  32'hFFFF_FFFF,  1'b1, 1'b1, 32'd0},
    '{lclr_pkg::CMD_ADD,     4'd0,  32'd100,        1'b0, 1'b0, 32'd0},
    '{lclr_pkg::CMD_ADD,     4'd0,  32'd50,         1'b0, 1'b0, 32'd0},
    '{lclr_pkg::CMD_READ,    4'd9,  32'd0,          1'b0, 1'b0, 32'd0},
    '{lclr_pkg::CMD_SUB,     4'd0,  32'd30,         1'b0, 1'b0, 32'd0},
    '{lclr_pkg::CMD_SUB,     4'd1,  32'd5,          1'b0, 1'b0, 32'd0},
    '{lclr_pkg::CMD_ADD,     4'd1,  32'd1,          1'b0, 1'b0, 32'd0},
    '{lclr_pkg::CMD_ADD,     4'd2,  32'd10000,      1'b0, 1'b0, 32'd0},
    '{lclr_pkg::CMD_RELEASE, 4'd0,  32'd0,          1'b0, 1'b0, 32'd0},
    '{lclr_pkg::CMD_READ,    4'd15, 32'hFFFF_FFFF,  1'b0, 1'b0, 32'd0},
    '{lclr_pkg::CMD_SUB,     4'd0,  32'hFFFF_FFFF,  1'b0, 1'b0, 32'd0},
    '{lclr_pkg::CMD_ADD,     4'd8,  32'd60,         1'b0, 1'b0, 32'd0},
    '{lclr_pkg::CMD_RELEASE, 4'd1,  32'd0,          1'b0, 1'b0, 32'd0},
    '{lclr_pkg::CMD_READ,    4'd0,  32'd0,          1'b0, 1'b0, 32'd0}
  };

  // Configuration of the random phases: limit, active count, item count
  localparam logic [DATA_W-1:0] PH_LIM [NPHASE] = '{
    32'hFFFF_FFFF, 32'd1000, 32'd0, 32'd50000, 32'd123456, 32'd10000, 32'hFFFF_FFFF
  };
  localparam logic [ACT_W-1:0] PH_ACT [NPHASE] = '{
    5'd16, 5'd4, 5'd0, 5'd31, 5'd7, 5'd1, 5'd2
  };
  localparam int PH_N [NPHASE] = '{250, 250, 150, 250, 250, 200, 200};
  localparam int HOLD_PHASE = 4;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [CMD_W-1:0]     command = '0;
  logic [CLIENT_W-1:0]  client = '0;
  logic [DATA_W-1:0]    delta = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 ok;
  logic [DATA_W-1:0]    total;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]    cfg_data = '0;

  limit_counter_with_local_reserves u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .client    (client),
    .delta     (delta),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ok        (ok),
    .total     (total),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Shadow copy of the counter state and configuration
  logic [DATA_W-1:0] loc_cnt [NCLI];
  logic [DATA_W-1:0] loc_res [NCLI];
  logic [DATA_W-1:0] pool_cnt;
  logic [DATA_W-1:0] resv_sum;
  logic [DATA_W-1:0] lim_r;
  logic [ACT_W-1:0]  act_r;

  reply_t want_q [$];

  int n_sent;
  int n_reads;
  int n_refused;
  int n_checked;
  int n_err;
  int burst_left;

  logic hold_go = 1'b0;
  logic hold_done = 1'b0;
  int   hold_cnt = 0;
  int   rx_mode = 0;
  int   mode_cnt = 0;

  function automatic logic [DATA_W-1:0] sat32(input logic [DATA_W-1:0] a,
                                              input logic [DATA_W-1:0] b);
    logic [DATA_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[DATA_W]) return '1;
    return s[DATA_W-1:0];
  endfunction

  // Free headroom under the limit, floored at zero
  function automatic logic [DATA_W-1:0] free_room();
    logic [DATA_W:0] used;
    logic [DATA_W:0] lim_w;
    used  = {1'b0, pool_cnt} + {1'b0, resv_sum};
    lim_w = {1'b0, lim_r};
    if (lim_w <= used) return '0;
    return lim_w[DATA_W-1:0] - used[DATA_W-1:0];
  endfunction

  // Return a client's count and reserve to the pool
  task automatic fold_back(input int c);
    pool_cnt = sat32(pool_cnt, loc_cnt[c]);
    loc_cnt[c] = '0;
    resv_sum = (resv_sum >= loc_res[c]) ? resv_sum - loc_res[c] : '0;
    loc_res[c] = '0;
  endtask

  // Carve a fresh reserve, half of it prefilled from the pool as far as the pool allows
  task automatic draw_reserve(input int c);
    logic [DATA_W-1:0] n;
    logic [DATA_W-1:0] r;
    logic [DATA_W-1:0] fill;
    n = (act_r == '0) ? 32'd1 : {{(DATA_W-ACT_W){1'b0}}, act_r};
    r = free_room() / n;
    loc_res[c] = r;
    resv_sum = sat32(resv_sum, r);
    fill = r / lclr_pkg::PREFILL_DIV;
    if (fill > pool_cnt) fill = pool_cnt;
    loc_cnt[c] = fill;
    pool_cnt = pool_cnt - fill;
  endtask

  // Apply one command to the shadow state and form its reply
  task automatic count_step(input logic [CMD_W-1:0] cmd, input logic [CLIENT_W-1:0] cl,
                            input logic [DATA_W-1:0] d, output reply_t r);
    logic [DATA_W-1:0] acc;
    int c;
    c = int'(cl);
    r.ok = 1'b1;
    r.total = '0;
    case (cmd)
      lclr_pkg::CMD_READ: begin
        acc = pool_cnt;
        for (int i = 0; i < NCLI; i++) acc = sat32(acc, loc_cnt[i]);
        r.total = acc;
      end
      lclr_pkg::CMD_RELEASE: fold_back(c);
      lclr_pkg::CMD_ADD: begin
        if (loc_cnt[c] <= loc_res[c] && loc_res[c] - loc_cnt[c] >= d) begin
          loc_cnt[c] = loc_cnt[c] + d;
        end else begin
          fold_back(c);
          if (free_room() < d) begin
            r.ok = 1'b0;
          end else begin
            pool_cnt = pool_cnt + d;
            draw_reserve(c);
          end
        end
      end
      default: begin
        if (loc_cnt[c] >= d) begin
          loc_cnt[c] = loc_cnt[c] - d;
        end else begin
          fold_back(c);
          if (pool_cnt < d) begin
            r.ok = 1'b0;
          end else begin
            pool_cnt = pool_cnt - d;
            draw_reserve(c);
          end
        end
      end
    endcase
  endtask

  // Register write; the shadow copy follows the same masking
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    if (idx == lclr_pkg::CFG_LIMIT) lim_r = data;
    else if (idx == lclr_pkg::CFG_ACTIVE) act_r = data[ACT_W-1:0];
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Wait until every reply is in and the block has settled
  task automatic drain();
    while (want_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Sender bursts: a random gap with valid low between bursts
  task automatic sender_pause();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = $urandom_range(0, 20);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  // Offer one item, hold it until taken, then record its reply
  task automatic put_item(input logic [CMD_W-1:0] cmd, input logic [CLIENT_W-1:0] cl,
                          input logic [DATA_W-1:0] d, input logic fixed,
                          input reply_t fixed_val);
    reply_t p;
    in_valid <= 1'b1;
    command <= cmd;
    client <= cl;
    delta <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    count_step(cmd, cl, d, p);
    want_q.push_back(fixed ? fixed_val : p);
    n_sent++;
    if (cmd == lclr_pkg::CMD_READ) n_reads++;
    if (!p.ok) n_refused++;
  endtask

  // Mostly amounts scaled to the limit per active client, some extremes and raw noise
  function automatic logic [DATA_W-1:0] pick_delta();
    int unsigned k;
    logic [DATA_W-1:0] nn;
    logic [DATA_W-1:0] scale;
    k = $urandom_range(0, 99);
    nn = (act_r == '0) ? 32'd1 : {{(DATA_W-ACT_W){1'b0}}, act_r};
    scale = lim_r / (nn * 4) + 32'd1;
    if (k < 5) return '0;
    if (k < 8) return '1;
    if (k < 15) return $urandom;
    if (k < 25) return $urandom_range(0, lim_r);
    return $urandom_range(0, scale);
  endfunction

  task automatic run_random(input int count);
    int unsigned k;
    int span;
    logic [CMD_W-1:0] cmd;
    logic [CLIENT_W-1:0] cl;
    reply_t none;
    none = '0;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 99);
      if (k < 42) cmd = lclr_pkg::CMD_ADD;
      else if (k < 70) cmd = lclr_pkg::CMD_SUB;
      else if (k < 85) cmd = lclr_pkg::CMD_READ;
      else cmd = lclr_pkg::CMD_RELEASE;
      // clients mostly within the active set
      span = (act_r == '0) ? 1 : ((int'(act_r) > NCLI) ? NCLI : int'(act_r));
      if ($urandom_range(0, 9) == 0) cl = CLIENT_W'($urandom_range(0, NCLI - 1));
      else cl = CLIENT_W'($urandom_range(0, span - 1));
      sender_pause();
      put_item(cmd, cl, pick_delta(), 1'b0, none);
    end
  endtask

  // Receiver: checks replies and stalls on its own pattern
  always @(posedge clk) begin
    reply_t w;
    if (out_valid && out_ready) begin
      if (want_q.size() == 0) begin
        if (n_err < 10)
          $display("unexpected reply: ok=%0d total=%08h", ok, total);
        n_err++;
      end else begin
        w = want_q.pop_front();
        n_checked++;
        if (w.ok !== ok || w.total !== total) begin
          if (n_err < 10)
            $display("reply mismatch: expected ok=%0d total=%08h, got ok=%0d total=%08h",
                     w.ok, w.total, ok, total);
          n_err++;
        end
      end
    end

    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else if (hold_go && !hold_done) begin
      // one long hold-off so the block backs up into its input
      hold_done <= 1'b1;
      hold_cnt <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      if (mode_cnt == 0) begin
        rx_mode <= $urandom_range(0, 3);
        mode_cnt <= $urandom_range(40, 250);
      end else begin
        mode_cnt <= mode_cnt - 1;
      end
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= (mode_cnt % 7) < 3;
      endcase
    end
  end

  // Run limit
  initial begin
    for (int cyc = 0; cyc < LIMIT_CYCLES; cyc++) @(posedge clk);
    $display("timeout after %0d cycles, %0d replies outstanding", LIMIT_CYCLES,
             want_q.size());
    $display("limit_counter_with_local_reserves_tb: errors");
    $finish;
  end

  // Main sequence
  initial begin
    reply_t fv;
    n_sent = 0;
    n_reads = 0;
    n_refused = 0;
    n_checked = 0;
    n_err = 0;
    burst_left = 0;
    for (int i = 0; i < NCLI; i++) begin
      loc_cnt[i] = '0;
      loc_res[i] = '0;
    end
    pool_cnt = '0;
    resv_sum = '0;
    lim_r = lclr_pkg::LIMIT_RESET;
    act_r = lclr_pkg::ACTIVE_RESET;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed items at the reset configuration
    for (int i = 0; i < DIR_N; i++) begin
      fv.ok = DIR_TAB[i].ok;
      fv.total = DIR_TAB[i].tot;
      sender_pause();
      put_item(DIR_TAB[i].cmd, DIR_TAB[i].cl, DIR_TAB[i].d, DIR_TAB[i].fixed, fv);
    end
    run_random(200);
    in_valid <= 1'b0;

    // random phases, each under its own configuration
    for (int p = 0; p < NPHASE; p++) begin
      drain();
      cfg_write(lclr_pkg::CFG_LIMIT, PH_LIM[p]);
      cfg_write(lclr_pkg::CFG_ACTIVE,
                {(DATA_W-ACT_W)'($urandom_range(0, 32'h07FF_FFFF)), PH_ACT[p]});
      if (p == 1) begin
        cfg_write(CFG_SPARE_A, '1);
        cfg_write(CFG_SPARE_B, $urandom);
      end
      if (p == HOLD_PHASE) hold_go <= 1'b1;
      run_random(PH_N[p]);
      in_valid <= 1'b0;
    end

    drain();
    repeat (60) @(posedge clk);

    $display("items %0d (reads %0d, refused %0d), replies checked %0d, mismatches %0d",
             n_sent, n_reads, n_refused, n_checked, n_err);
    $display("%0d configurations incl. zero limit, zero and wide active counts",
             NPHASE + 1);
    if (n_err == 0 && want_q.size() == 0) begin
      $display("limit_counter_with_local_reserves_tb: clean");
    end else begin
      $display("limit_counter_with_local_reserves_tb: errors");
    end
    $finish;
  end

endmodule

/* limit_counter_with_local_reserves.f */
design/lclr_pkg.sv
design/lclr_seq.sv
design/lclr_div.sv
design/lclr_dp.sv
design/limit_counter_with_local_reserves.sv
bench/limit_counter_with_local_reserves_tb.sv
